// ----- design/gapd_pkg.sv -----
// Package with shared constants, types and a helper function of the gap-aware p-distance block.
`default_nettype none
package gapd_pkg;

  localparam int CHAR_BITS     = 8;
  localparam int COUNT_BITS    = 16;
  localparam int FRACTION_BITS = 16;
  localparam int SUM_BITS      = COUNT_BITS + 2;
  localparam int REM_BITS      = SUM_BITS + 1;
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int STEP_BITS     = $clog2(FRACTION_BITS);

  localparam logic [CHAR_BITS-1:0] GAP_RESET = CHAR_BITS'(45);
  localparam logic [FRAC_W-1:0]    FRAC_ONE  = FRAC_W'(1) << FRACTION_BITS;

  typedef logic [COUNT_BITS-1:0] count_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // a site is transferred this cycle
    logic start;   // the site is the last one: latch totals and start the divide
    logic step;    // one restoring division step
    logic push;    // move the finished result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (v == '1) ? v : count_t'(v + 1'b1);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/gapd_in_if.sv -----
// Input channel carrying one aligned character pair and the last-site flag.
`default_nettype none
interface gapd_in_if;
  logic                           valid;
  logic                           ready;
  logic [gapd_pkg::CHAR_BITS-1:0] char_a;
  logic [gapd_pkg::CHAR_BITS-1:0] char_b;
  logic                           last_site;

  modport source (output valid, output char_a, output char_b, output last_site, input ready);
  modport sink   (input valid, input char_a, input char_b, input last_site, output ready);
endinterface
`default_nettype wire

// ----- design/gapd_out_if.sv -----
// Result channel carrying the counts, the distance fraction and the incomparable flag.
`default_nettype none
interface gapd_out_if;
  logic                          valid;
  logic                          ready;
  logic [gapd_pkg::COUNT_BITS-1:0] mismatch_count;
  logic [gapd_pkg::COUNT_BITS-1:0] site_count;
  logic [gapd_pkg::FRAC_W-1:0]     distance_fraction;
  logic                          incomparable;

  modport source (output valid, output mismatch_count, output site_count,
                  output distance_fraction, output incomparable, input ready);
  modport sink   (input valid, input mismatch_count, input site_count,
                  input distance_fraction, input incomparable, output ready);
endinterface
`default_nettype wire

// ----- design/gapd_cfg_if.sv -----
// Configuration write channel carrying the gap character code.
`default_nettype none
interface gapd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gapd_pkg::CHAR_BITS-1:0] gap_code;

  modport source (output valid, output gap_code, input ready);
  modport sink   (input valid, input gap_code, output ready);
endinterface
`default_nettype wire

// ----- design/gapd_ctrl.sv -----
// Controller state machine: site intake, division sequencing and result hand-off.
`default_nettype none
module gapd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_last,
  output logic                     in_ready,
  input  wire gapd_pkg::dp_status_t status,
  output gapd_pkg::ctrl_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [gapd_pkg::STEP_BITS-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          cmd.start = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == gapd_pkg::STEP_BITS'(gapd_pkg::FRACTION_BITS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/gapd_dp.sv -----
// Datapath: gap register, site counters, totals, restoring divider and output register.
`default_nettype none
module gapd_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire gapd_pkg::ctrl_cmd_t            cmd,
  output gapd_pkg::dp_status_t                status,
  input  wire logic [gapd_pkg::CHAR_BITS-1:0] char_a,
  input  wire logic [gapd_pkg::CHAR_BITS-1:0] char_b,
  input  wire logic                           cfg_we,
  input  wire logic [gapd_pkg::CHAR_BITS-1:0] cfg_gap_code,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic [gapd_pkg::COUNT_BITS-1:0]     out_mismatch_count,
  output logic [gapd_pkg::COUNT_BITS-1:0]     out_site_count,
  output logic [gapd_pkg::FRAC_W-1:0]         out_distance_fraction,
  output logic                                out_incomparable
);

  localparam int CB = gapd_pkg::COUNT_BITS;
  localparam int SB = gapd_pkg::SUM_BITS;
  localparam int RB = gapd_pkg::REM_BITS;
  localparam int FB = gapd_pkg::FRACTION_BITS;

  logic [gapd_pkg::CHAR_BITS-1:0] gap_code_r;
  gapd_pkg::count_t ident_r, subst_r, sgap_r, dgap_r;
  gapd_pkg::count_t ident_nxt, subst_nxt, sgap_nxt, dgap_nxt;

  logic ga, gb;
  logic [CB:0]   mism, gaps;
  logic [SB-1:0] comp, sites;
  logic          incomp;

  // Job and divider registers.
  gapd_pkg::count_t mism_sat_r, sites_sat_r;
  logic             incomp_r, special_r;
  logic [SB-1:0]    den_r;
  logic [RB-1:0]    rem_r, rem_shift;
  logic [FB-1:0]    quot_r;
  logic             ge;

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_code_r <= gapd_pkg::GAP_RESET;
    end else if (cfg_we) begin
      gap_code_r <= cfg_gap_code;
    end
  end

  // Site classification and saturating counter update.
  always_comb begin
    ga        = (char_a == gap_code_r);
    gb        = (char_b == gap_code_r);
    ident_nxt = ident_r;
    subst_nxt = subst_r;
    sgap_nxt  = sgap_r;
    dgap_nxt  = dgap_r;
    if (ga && gb) begin
      dgap_nxt = gapd_pkg::sat_inc(dgap_r);
    end else if (ga || gb) begin
      sgap_nxt = gapd_pkg::sat_inc(sgap_r);
    end else if (char_a == char_b) begin
      ident_nxt = gapd_pkg::sat_inc(ident_r);
    end else begin
      subst_nxt = gapd_pkg::sat_inc(subst_r);
    end
  end

  // Totals over the counts that include the last site.
  always_comb begin
    mism   = {1'b0, subst_nxt} + {1'b0, sgap_nxt};
    gaps   = {1'b0, sgap_nxt} + {1'b0, dgap_nxt};
    comp   = {2'b00, ident_nxt} + {1'b0, mism};
    sites  = comp + {2'b00, dgap_nxt};
    incomp = {gaps, 1'b0} > sites;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ident_r <= '0;
      subst_r <= '0;
      sgap_r  <= '0;
      dgap_r  <= '0;
    end else if (cmd.accept) begin
      if (cmd.start) begin
        ident_r <= '0;
        subst_r <= '0;
        sgap_r  <= '0;
        dgap_r  <= '0;
      end else begin
        ident_r <= ident_nxt;
        subst_r <= subst_nxt;
        sgap_r  <= sgap_nxt;
        dgap_r  <= dgap_nxt;
      end
    end
  end

  always_comb begin
    rem_shift = {rem_r[RB-2:0], 1'b0};
    ge        = rem_shift >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mism_sat_r  <= mism[CB] ? '1 : mism[CB-1:0];
      sites_sat_r <= (|sites[SB-1:CB]) ? '1 : sites[CB-1:0];
      incomp_r    <= incomp;
      // Too many gaps, no comparable site or all comparable sites mismatched give one.
      special_r   <= incomp || (comp == '0) || ({1'b0, mism} >= comp);
      den_r       <= comp;
      rem_r       <= {{(RB - CB - 1){1'b0}}, mism};
      quot_r      <= '0;
    end else if (cmd.step) begin
      rem_r  <= ge ? RB'(rem_shift - {1'b0, den_r}) : rem_shift;
      quot_r <= {quot_r[FB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_mismatch_count    <= mism_sat_r;
      out_site_count        <= sites_sat_r;
      out_distance_fraction <= special_r ? gapd_pkg::FRAC_ONE : {1'b0, quot_r};
      out_incomparable      <= incomp_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign status.out_free = !out_valid_r || out_ready;

endmodule
`default_nettype wire

// ----- design/gap_aware_p_distance.sv -----
// Gap-aware pairwise p-distance, one result per sequence pair.
// Sites are taken one per cycle while intake is open. After the last site's
// transfer, intake stops for the 16 restoring division steps and the hand-off,
// and stays stopped while the output register still holds an untaken result.
// The result becomes valid once the divide ends and the output register takes it.
// Reset clears all counters and the output valid, and sets the gap code to 45.
`default_nettype none
module gap_aware_p_distance (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gapd_in_if.sink    in_ch,
  gapd_out_if.source out_ch,
  gapd_cfg_if.sink   cfg_ch
);

  gapd_pkg::ctrl_cmd_t  cmd;
  gapd_pkg::dp_status_t status;

  assign cfg_ch.ready = 1'b1;

  gapd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_site),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  gapd_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .char_a                (in_ch.char_a),
    .char_b                (in_ch.char_b),
    .cfg_we                (cfg_ch.valid),
    .cfg_gap_code          (cfg_ch.gap_code),
    .out_ready             (out_ch.ready),
    .out_valid             (out_ch.valid),
    .out_mismatch_count    (out_ch.mismatch_count),
    .out_site_count        (out_ch.site_count),
    .out_distance_fraction (out_ch.distance_fraction),
    .out_incomparable      (out_ch.incomparable)
  );

endmodule
`default_nettype wire
